FILE: rtl/core/mouse_motion_spi_frame_bridge_unit_assert.svh
// Assertion macros shared by the mouse motion SPI frame bridge RTL.
// No dependencies; include with the bare file name.
`ifndef MOUSE_MOTION_SPI_FRAME_BRIDGE_UNIT_ASSERT_SVH
`define MOUSE_MOTION_SPI_FRAME_BRIDGE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MMSFB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mmsfb: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MMSFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mmsfb: next-cycle check failed");

`endif

FILE: rtl/core/mmsfb_pkg.sv
// Shared types, constants and saturating helpers for the mouse frame bridge.
// No dependencies.
package mmsfb_pkg;

	localparam int FRAME_LEN = 10;
	localparam int IDX_W     = 4;

	localparam logic [7:0] SYNC_RESET = 8'hAA;

	typedef enum logic [1:0] {
		OP_REPORT = 2'd0,
		OP_BYTE   = 2'd1,
		OP_TICK   = 2'd2
	} opcode_t;

	typedef logic [7:0] frame_t [FRAME_LEN];

	// Snapshot inputs handed to the frame builder.
	typedef struct packed {
		logic [7:0]  sync;
		logic [15:0] buttons;
		logic [15:0] sum_x;
		logic [15:0] sum_y;
		logic [7:0]  sum_wheel;
		logic [7:0]  sum_hwheel;
	} snap_t;

	function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		begin
			s = {a[15], a} + {b[15], b};
			if (s[16] != s[15])
				sat_add16 = s[16] ? 16'h8000 : 16'h7FFF;
			else
				sat_add16 = s[15:0];
		end
	endfunction

	function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		begin
			s = {a[7], a} + {b[7], b};
			if (s[8] != s[7])
				sat_add8 = s[8] ? 8'h80 : 8'h7F;
			else
				sat_add8 = s[7:0];
		end
	endfunction

endpackage

FILE: rtl/core/mmsfb_frame_build.sv
// Frame assembly: lays out the 10-byte frame and its XOR check byte.
// Depends on mmsfb_pkg.
module mmsfb_frame_build
	import mmsfb_pkg::*;
(
	input  snap_t  snap,
	output frame_t frame
);

	logic [7:0] body [FRAME_LEN-1];
	logic [7:0] chk;

	always_comb begin
		body[0] = snap.sync;
		body[1] = snap.buttons[7:0];
		body[2] = snap.buttons[15:8];
		body[3] = snap.sum_x[7:0];
		body[4] = snap.sum_x[15:8];
		body[5] = snap.sum_y[7:0];
		body[6] = snap.sum_y[15:8];
		body[7] = snap.sum_wheel;
		body[8] = snap.sum_hwheel;
	end

	// XOR over bytes 0..8
	always_comb begin
		chk = 8'h00;
		for (int k = 0; k < FRAME_LEN-1; k++) begin
			chk = chk ^ body[k];
		end
	end

	always_comb begin
		for (int k = 0; k < FRAME_LEN-1; k++) begin
			frame[k] = body[k];
		end
		frame[FRAME_LEN-1] = chk;
	end

endmodule

FILE: rtl/core/mouse_motion_spi_frame_bridge_unit.sv
// Mouse motion to SPI frame bridge: report accumulation, frame snapshot, byte stepping.
// Depends on mmsfb_pkg, mmsfb_frame_build and the assertion macro header.
//
// Usage
//   Slave stream (s_*): one word per event. s_tuser is the opcode (mouse report,
//   SPI byte clocked out, service tick; code 3 is a no-op). s_tdata carries the
//   report deltas, buttons and the two chip-select flags.
//   Master stream (m_*): exactly one status word per input word, in order:
//   the frame byte now loaded for the next transfer plus data-ready, armed and
//   pending flags, all as they stand after the event.
//   APB port: one register, sync_byte at address 0; it only affects frames
//   built after the write.
// Timing
//   Two registers deep: input word lands in the _s1 register, then the state update
//   and status word are formed from it and registered into the bridge state and m_tdata.
//   One word per cycle sustained while m_tready stays high; the state update loop sets that.
// Reset
//   Accumulators and flags clear, the index goes to 0 and the frame store holds
//   the idle frame (sync, eight zeros, sync) built from the reset sync byte.
// Stall
//   While m_tready is low the status word holds; one more word is taken into
//   the _s1 register, then s_tready drops until the output drains.
module mouse_motion_spi_frame_bridge_unit
	import mmsfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] delta_x, [31:16] delta_y, [39:32] wheel_step, [47:40] hwheel_step,
	// [63:48] button_bits, [64] first_of_select, [65] select_released, rest zero
	input  logic [71:0] s_tdata,
	// [1:0] opcode
	input  logic [1:0]  s_tuser,
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] tx_byte, [8] data_ready, [9] frame_armed, [10] data_pending, rest zero
	output logic [15:0] m_tdata
);

	// ---------------- configuration ----------------
	logic [7:0] sync_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? {24'h0, sync_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
		end else if (cfg_wr) begin
			sync_q <= pwdata[7:0];
		end
	end

	// ---------------- input register ----------------
	logic        valid_s1;
	opcode_t     op_s1;
	logic [15:0] dx_s1, dy_s1, btn_s1;
	logic [7:0]  wh_s1, hwh_s1;
	logic        first_s1, released_s1;
	logic        advance, fire, in_acc;

	assign advance  = !m_tvalid || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1       <= opcode_t'(s_tuser);
			dx_s1       <= s_tdata[15:0];
			dy_s1       <= s_tdata[31:16];
			wh_s1       <= s_tdata[39:32];
			hwh_s1      <= s_tdata[47:40];
			btn_s1      <= s_tdata[63:48];
			first_s1    <= s_tdata[64];
			released_s1 <= s_tdata[65];
		end
	end

	// ---------------- bridge state ----------------
	logic [15:0]    sum_x_q, sum_y_q, held_q, pressed_q;
	logic [7:0]     sum_wh_q, sum_hwh_q;
	logic           pending_q, armed_q, sent_q, ready_q;
	logic [IDX_W-1:0] idx_q;
	frame_t         frame_q;

	logic [15:0]    n_sum_x, n_sum_y, n_held, n_pressed;
	logic [7:0]     n_sum_wh, n_sum_hwh;
	logic           n_pending, n_armed, n_sent, n_ready;
	logic [IDX_W-1:0] n_idx, idx_base, idx_inc;
	frame_t         n_frame, built;
	snap_t          snap;
	logic [15:0]    snap_btn;
	logic           retire_armed;

	assign snap_btn = held_q | pressed_q;
	assign snap = '{sync: sync_q, buttons: snap_btn, sum_x: sum_x_q, sum_y: sum_y_q,
			sum_wheel: sum_wh_q, sum_hwheel: sum_hwh_q};

	mmsfb_frame_build u_build (
		.snap  (snap),
		.frame (built)
	);

	assign idx_base = first_s1 ? '0 : idx_q;
	assign idx_inc  = idx_base + 1'b1;
	// armed as seen after a possible retire on a tick
	assign retire_armed = (sent_q && released_s1) ? 1'b0 : armed_q;

	always_comb begin
		n_sum_x   = sum_x_q;
		n_sum_y   = sum_y_q;
		n_sum_wh  = sum_wh_q;
		n_sum_hwh = sum_hwh_q;
		n_held    = held_q;
		n_pressed = pressed_q;
		n_pending = pending_q;
		n_armed   = armed_q;
		n_sent    = sent_q;
		n_ready   = ready_q;
		n_idx     = idx_q;
		n_frame   = frame_q;
		unique case (op_s1)
			OP_REPORT: begin
				n_sum_x   = sat_add16(sum_x_q, dx_s1);
				n_sum_y   = sat_add16(sum_y_q, dy_s1);
				n_sum_wh  = sat_add8(sum_wh_q, wh_s1);
				n_sum_hwh = sat_add8(sum_hwh_q, hwh_s1);
				n_pressed = pressed_q | btn_s1;
				n_held    = btn_s1;
				n_pending = 1'b1;
			end
			OP_BYTE: begin
				if (idx_inc == IDX_W'(FRAME_LEN)) begin
					n_idx   = '0;
					n_ready = 1'b0;
					n_sent  = 1'b1;
				end else begin
					n_idx = idx_inc;
				end
			end
			OP_TICK: begin
				if (sent_q && released_s1) begin
					n_sent  = 1'b0;
					n_armed = 1'b0;
				end
				if (!retire_armed && pending_q) begin
					n_frame   = built;
					n_sum_x   = '0;
					n_sum_y   = '0;
					n_sum_wh  = '0;
					n_sum_hwh = '0;
					n_pressed = '0;
					// transient press keeps data pending
					n_pending = (snap_btn != held_q);
					n_idx     = '0;
					n_armed   = 1'b1;
					n_ready   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q   <= '0;
			sum_y_q   <= '0;
			sum_wh_q  <= '0;
			sum_hwh_q <= '0;
			held_q    <= '0;
			pressed_q <= '0;
			pending_q <= 1'b0;
			armed_q   <= 1'b0;
			sent_q    <= 1'b0;
			ready_q   <= 1'b0;
			idx_q     <= '0;
			// idle frame: sync, zeros, sync
			for (int k = 0; k < FRAME_LEN; k++) begin
				frame_q[k] <= (k == 0 || k == FRAME_LEN-1) ? SYNC_RESET : 8'h00;
			end
		end else if (fire) begin
			sum_x_q   <= n_sum_x;
			sum_y_q   <= n_sum_y;
			sum_wh_q  <= n_sum_wh;
			sum_hwh_q <= n_sum_hwh;
			held_q    <= n_held;
			pressed_q <= n_pressed;
			pending_q <= n_pending;
			armed_q   <= n_armed;
			sent_q    <= n_sent;
			ready_q   <= n_ready;
			idx_q     <= n_idx;
			frame_q   <= n_frame;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_tdata <= {5'b0, n_pending, n_armed, n_ready, n_frame[n_idx]};
		end
	end

	// ---------------- checks ----------------
`include "mouse_motion_spi_frame_bridge_unit_assert.svh"

	`MMSFB_ASSERT_NOW(a_idx_range, clk, arst_n, 1'b1, idx_q < IDX_W'(FRAME_LEN))
	`MMSFB_ASSERT_NEXT(a_hold_on_stall, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`MMSFB_ASSERT_NOW(a_no_take_on_stall, clk, arst_n, valid_s1 && !advance, !in_acc)

endmodule
